### sv/rqfb_pkg.sv
package rqfb_pkg;

    localparam int ITEM_BITS  = 32;
    localparam int FIELD_BITS = 5;

    localparam logic [FIELD_BITS-1:0] QLEN_RESET = 5'd16;

    typedef enum logic [2:0] {
        REQ_SEND_BACK  = 3'd0,
        REQ_SEND_FRONT = 3'd1,
        REQ_RECEIVE    = 3'd2,
        REQ_PEEK       = 3'd3,
        REQ_RESET      = 3'd4
    } t_req_e;

    typedef struct packed {
        logic [2:0]           req_type;
        logic [ITEM_BITS-1:0] item_in;
    } t_req;

    typedef struct packed {
        logic                  ok;
        logic [ITEM_BITS-1:0]  item_out;
        logic [FIELD_BITS-1:0] fill_count;
        logic [FIELD_BITS-1:0] free_slots;
    } t_res;

endpackage

### sv/rqfb_ram.sv
module rqfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

    assign o_rdata = r_q;

endmodule

### sv/ring_queue_front_back_insert.sv
// Ring queue with push at back or front, pop, peek and reset, one request per
// clock. A request is taken whenever start is high; busy never rises, so one
// request can be issued every cycle. Its result is on o_res with o_done for
// one cycle: the request register holds the item, then the slot RAM read and
// the result register load together. Results come out in request order and
// cannot be stalled. Each request touches the single RAM port at most once
// (write for a send, read for a receive or peek), which is what allows the
// one-per-cycle rate. Slot contents are not cleared at reset; only indices and
// the count are. Write i_cfg_data only while no request is in flight.
module ring_queue_front_back_insert #(
    parameter int DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  rqfb_pkg::t_req                     i_req,
    output logic                               o_done,
    output rqfb_pkg::t_res                     o_res,
    input  logic                               i_cfg_we,
    input  logic [rqfb_pkg::FIELD_BITS-1:0]    i_cfg_data
);

    import rqfb_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > FIELD_BITS) ? CW : FIELD_BITS;

    // request stage
    logic                  r_in_vld;
    t_req                  r_in;

    // queue state
    logic [FIELD_BITS-1:0] r_qlen;
    logic [IW-1:0]         r_head, n_head;
    logic [IW-1:0]         r_tail, n_tail;
    logic [CW-1:0]         r_count, n_count;

    // result stage
    logic                  r_res_vld;
    logic                  r_ok, n_ok;
    logic                  r_rd, n_rd;
    logic [FIELD_BITS-1:0] r_fill, n_fill;
    logic [FIELD_BITS-1:0] r_free, n_free;

    logic [LW-1:0]         qlen_w;
    logic [LW-1:0]         depth_w;
    logic [LW-1:0]         len_w;
    logic [CW-1:0]         len;
    logic [CW-1:0]         head_inc;
    logic [CW-1:0]         tail_inc;
    logic [IW-1:0]         head_fwd;
    logic [IW-1:0]         tail_fwd;
    logic [IW-1:0]         head_back;
    logic [CW-1:0]         free_cnt;
    logic                  has_room;
    logic                  not_empty;

    logic                  ram_we;
    logic [IW-1:0]         ram_addr;
    logic [ITEM_BITS-1:0]  ram_q;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= QLEN_RESET;
        end else if (i_cfg_we) begin
            r_qlen <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_req;
        end
    end

    // effective length: zero acts as one, clamp to the ring size
    always_comb begin
        qlen_w  = LW'(r_qlen);
        depth_w = LW'(DEPTH);
        if (r_qlen == '0) begin
            len_w = LW'(1);
        end else if (qlen_w > depth_w) begin
            len_w = depth_w;
        end else begin
            len_w = qlen_w;
        end
        len = CW'(len_w);
    end

    always_comb begin
        head_inc  = CW'(r_head) + CW'(1);
        tail_inc  = CW'(r_tail) + CW'(1);
        head_fwd  = (head_inc >= len) ? '0 : IW'(head_inc);
        tail_fwd  = (tail_inc >= len) ? '0 : IW'(tail_inc);
        head_back = (r_head == '0) ? IW'(len - CW'(1)) : (r_head - IW'(1));
        has_room  = (r_count < len);
        not_empty = (r_count != '0);
    end

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_ok     = 1'b0;
        n_rd     = 1'b0;
        ram_we   = 1'b0;
        ram_addr = r_head;
        if (r_in_vld) begin
            unique case (t_req_e'(r_in.req_type))
                REQ_SEND_BACK: begin
                    ram_addr = r_tail;
                    if (has_room) begin
                        ram_we  = 1'b1;
                        n_tail  = tail_fwd;
                        n_count = r_count + CW'(1);
                        n_ok    = 1'b1;
                    end
                end
                REQ_SEND_FRONT: begin
                    ram_addr = head_back;
                    if (has_room) begin
                        ram_we  = 1'b1;
                        n_head  = head_back;
                        n_count = r_count + CW'(1);
                        n_ok    = 1'b1;
                    end
                end
                REQ_RECEIVE: begin
                    if (not_empty) begin
                        n_head  = head_fwd;
                        n_count = r_count - CW'(1);
                        n_ok    = 1'b1;
                        n_rd    = 1'b1;
                    end
                end
                REQ_PEEK: begin
                    if (not_empty) begin
                        n_ok = 1'b1;
                        n_rd = 1'b1;
                    end
                end
                REQ_RESET: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                    n_ok    = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // free space saturates at zero when the length shrank under held items
    always_comb begin
        free_cnt = (n_count >= len) ? '0 : (len - n_count);
        n_fill   = FIELD_BITS'(LW'(n_count));
        n_free   = FIELD_BITS'(LW'(free_cnt));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_res_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok   <= n_ok;
        r_rd   <= n_rd;
        r_fill <= n_fill;
        r_free <= n_free;
    end

    rqfb_ram #(
        .WIDTH (ITEM_BITS),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_in.item_in),
        .o_rdata (ram_q)
    );

    assign o_done          = r_res_vld;
    assign o_res.ok        = r_ok;
    assign o_res.item_out  = r_rd ? ram_q : '0;
    assign o_res.fill_count = r_fill;
    assign o_res.free_slots = r_free;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("accepted item produced no result");

    a_fail_zero_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_res.ok) |-> (o_res.item_out == '0))
        else $error("failed request returned an item");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |=> $stable(r_count))
        else $error("count changed without a request");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> (r_count <= CW'(DEPTH)))
        else $error("count exceeds ring size");

endmodule
